FILE: rtl/core/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types and constants for the reversible deque engine: command and
// status codes, payload structs, controller state and control links.
// ----------------------------------------------------------------------------
package rde_pkg;

    // Default store depth for the top level.
    localparam int DEFAULT_DEPTH = 1024;

    // Fixed field widths of the request and result payloads.
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // Command codes carried in a request.
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TAKE    = 3'd4;

    // Status codes returned in a result.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Request payload.
    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    // Result payload.
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value_out;
        logic [COUNT_W-1:0]        count;
    } t_out_item;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;      // Execute the request presented at the input.
        logic load_out;  // Move the pending result into the output register.
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_read;  // The presented request is a take with data.
        logic out_free;    // The output register can take a new result.
    } t_ctrl_status;

endpackage

FILE: rtl/core/rde_ram.sv
// ----------------------------------------------------------------------------
// rde_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/rde_datapath.sv
// ----------------------------------------------------------------------------
// rde_datapath
// Deque pointers, flags, element store, pending result and output register.
// ----------------------------------------------------------------------------
module rde_datapath #(
    parameter int DEPTH = rde_pkg::DEFAULT_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rde_pkg::t_ctrl_cmd    i_cmd,
    output rde_pkg::t_ctrl_status o_status,
    input  rde_pkg::t_in_item     i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rde_pkg::t_out_item    o_out_item
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // Deque state.
    logic [PW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_rev, n_rev;
    logic          r_err, n_err;

    // Pending result of the request in flight.
    logic [rde_pkg::STATUS_W-1:0] r_pend_status, n_pend_status;
    logic [CW-1:0]                r_pend_count, n_pend_count;
    logic                         r_pend_data, n_pend_data;

    // Output register.
    logic               r_out_valid;
    rde_pkg::t_out_item r_out_item;

    // Store interface.
    logic                        wr_en;
    logic                        rd_en;
    logic [PW-1:0]               tail_slot;
    logic [PW-1:0]               front_slot;
    logic [rde_pkg::VALUE_W-1:0] rd_data;

    logic                        is_empty;
    logic                        is_full;
    logic [SW-1:0]               tail_sum;
    logic [SW-1:0]               tail_wrap;
    logic [SW-1:0]               back_sum;
    logic [SW-1:0]               back_wrap;
    logic [PW-1:0]               head_inc;
    logic [CW+rde_pkg::COUNT_W-1:0] count_ext;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CW'(DEPTH));

    // Slot after the last element and slot of the last element, wrapped once.
    assign tail_sum  = SW'(r_head) + SW'(r_count);
    assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
    assign back_sum  = tail_sum - SW'(1);
    assign back_wrap = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
    assign tail_slot = tail_wrap[PW-1:0];
    assign front_slot = r_rev ? back_wrap[PW-1:0] : r_head;
    assign head_inc  = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + PW'(1);

    // Status toward the controller.
    assign o_status.needs_read = (i_in_item.cmd == rde_pkg::CMD_TAKE) && !r_err && !is_empty;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    // Command execution: next pointers, flags and pending result.
    always_comb begin
        n_head        = r_head;
        n_count       = r_count;
        n_rev         = r_rev;
        n_err         = r_err;
        n_pend_status = r_pend_status;
        n_pend_count  = r_pend_count;
        n_pend_data   = r_pend_data;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        if (i_cmd.exec) begin
            n_pend_status = rde_pkg::ST_OK;
            n_pend_data   = 1'b0;
            if (i_in_item.cmd == rde_pkg::CMD_CLEAR) begin
                n_head  = '0;
                n_count = '0;
                n_rev   = 1'b0;
                n_err   = 1'b0;
            end else if (r_err) begin
                n_pend_status = rde_pkg::ST_ERROR;
            end else begin
                case (i_in_item.cmd)
                    rde_pkg::CMD_APPEND: begin
                        if (is_full) begin
                            n_pend_status = rde_pkg::ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    rde_pkg::CMD_REVERSE: begin
                        n_rev = !r_rev;
                    end
                    rde_pkg::CMD_DELETE, rde_pkg::CMD_TAKE: begin
                        if (is_empty) begin
                            if (i_in_item.cmd == rde_pkg::CMD_DELETE) begin
                                n_err         = 1'b1;
                                n_pend_status = rde_pkg::ST_ERROR;
                            end else begin
                                n_pend_status = rde_pkg::ST_EMPTY;
                            end
                        end else begin
                            if (i_in_item.cmd == rde_pkg::CMD_TAKE) begin
                                rd_en       = 1'b1;
                                n_pend_data = 1'b1;
                            end
                            if (!r_rev) begin
                                n_head = head_inc;
                            end
                            n_count = r_count - CW'(1);
                        end
                    end
                    default: begin
                        n_pend_status = rde_pkg::ST_OK;
                    end
                endcase
            end
            n_pend_count = n_count;
        end
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_rev   <= n_rev;
            r_err   <= n_err;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pending result registers.
    always_ff @(posedge i_clk) begin
        r_pend_status <= n_pend_status;
        r_pend_count  <= n_pend_count;
        r_pend_data   <= n_pend_data;
    end

    // Output payload register.
    assign count_ext = {{rde_pkg::COUNT_W{1'b0}}, r_pend_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_item.status    <= r_pend_status;
            r_out_item.value_out <= r_pend_data ? rd_data : '0;
            r_out_item.count     <= count_ext[rde_pkg::COUNT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Element store.
    rde_ram #(
        .WIDTH(rde_pkg::VALUE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(tail_slot),
        .i_wr_data(i_in_item.value),
        .i_rd_en  (rd_en),
        .i_rd_addr(front_slot),
        .o_rd_data(rd_data)
    );

endmodule

FILE: rtl/core/rde_ctrl.sv
// ----------------------------------------------------------------------------
// rde_ctrl
// Request sequencer: accepts a request, waits out the store read of a take,
// and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module rde_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  rde_pkg::t_ctrl_status i_status,
    output rde_pkg::t_ctrl_cmd    o_cmd
);

    rde_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rde_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rde_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.needs_read ? rde_pkg::S_READ : rde_pkg::S_DONE;
                end
            end
            rde_pkg::S_READ: begin
                n_state = rde_pkg::S_DONE;
            end
            rde_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    n_state = rde_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rde_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_stall     = 1'b1;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            rde_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.exec = i_in_valid;
            end
            rde_pkg::S_DONE: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/reversible_deque_engine.sv
// ----------------------------------------------------------------------------
// reversible_deque_engine
// Ring-buffer deque with orientation flag and sticky error, one result per
// request.
// ----------------------------------------------------------------------------
// A request holds the sequencer from its acceptance in S_IDLE through S_DONE,
// which loads its result into the output register. A take that returns an
// element passes through S_READ in between for the registered read of the
// element store. A new request is accepted while the previous result still
// waits in the output register; a result that finds the output register full
// holds the sequencer, and stalls the input, until the register drains.
// There is no clearing pass after reset: the store is only read at live
// entries.
module reversible_deque_engine #(
    parameter int DEPTH = rde_pkg::DEFAULT_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rde_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rde_pkg::t_out_item o_out_item
);

    rde_pkg::t_ctrl_cmd    ctrl_cmd;
    rde_pkg::t_ctrl_status ctrl_status;

    // Sequencer.
    rde_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_status  (ctrl_status),
        .o_cmd     (ctrl_cmd)
    );

    // Pointers, store and result registers.
    rde_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ctrl_cmd),
        .o_status   (ctrl_status),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

endmodule
